/* design/hufd_pkg.sv */
`default_nettype none

package hufd_pkg;

  localparam int unsigned SymW   = 8;
  localparam int unsigned ChildW = 10;
  localparam int unsigned IdxW   = 9;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PadW   = 3;
  localparam int unsigned RemW   = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 2;

  // tree node as held in the store, symbol in the low bits
  typedef struct packed {
    logic [ChildW-1:0] right;
    logic [ChildW-1:0] left;
    logic [SymW-1:0]   sym;
  } node_t;

  localparam int unsigned NodeW = $bits(node_t);

  localparam node_t AbsentNode = '{right: '1, left: '1, sym: '0};

  localparam logic [CfgIdxW-1:0] RegPadBits   = 1'd0;
  localparam logic [CfgIdxW-1:0] RegRootIndex = 1'd1;

  localparam logic ReqLoad   = 1'b0;
  localparam logic ReqDecode = 1'b1;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRoot  = 5'b00010,
    StCur   = 5'b00100,
    StStep  = 5'b01000,
    StChk   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

/* design/hufd_ram.sv */
`default_nettype none

module hufd_ram #(
  parameter int unsigned Width = 28,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/huffman_tree_walk_decoder.sv */
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: node and byte fields, tuser: kind, start
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: symbol, tlast: last symbol of the byte
// cfg       in   cfg_we_i (always taken)      cfg_idx_i, cfg_wdata_i
//
// a load word is written into the tree store as it is accepted, if its index is in range.
// a byte word is accepted, then the root and current nodes are read; each decoded bit
// either goes back to the root on a missing child or reads the child through the one read
// port of the tree store and checks it for a leaf; a flush step ends the byte, then any pending symbol is sent.
// reset clears the control state and the config registers; the tree store is undefined until loaded.
// a stalled output holds the walk only when a further symbol must be pushed.
`default_nettype none

module huffman_tree_walk_decoder #(
  parameter int unsigned NODE_DEPTH    = 512,
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // node_index, node_symbol, node_left, node_right, data_byte, zero fill
  input  wire logic [hufd_pkg::InDataW-1:0]       s_axis_tdata,
  // req_type, start_of_stream
  input  wire logic [hufd_pkg::InUserW-1:0]       s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // symbol
  output logic [7:0]                              m_axis_tdata,
  output logic                                    m_axis_tlast,
  input  wire logic                               cfg_we_i,
  input  wire logic [hufd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [hufd_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(NODE_DEPTH);
  localparam int unsigned IdxW  = hufd_pkg::IdxW;
  localparam int unsigned SymW  = hufd_pkg::SymW;
  localparam int unsigned CW    = hufd_pkg::ChildW;
  localparam int unsigned RemW  = hufd_pkg::RemW;

  // input fields
  logic [IdxW-1:0]            in_idx;
  logic [SymW-1:0]            in_sym;
  logic [CW-1:0]              in_left;
  logic [CW-1:0]              in_right;
  logic [hufd_pkg::ByteW-1:0] in_byte;
  logic                       in_req;
  logic                       in_start;

  assign in_idx   = s_axis_tdata[8:0];
  assign in_sym   = s_axis_tdata[16:9];
  assign in_left  = s_axis_tdata[26:17];
  assign in_right = s_axis_tdata[36:27];
  assign in_byte  = s_axis_tdata[44:37];
  assign in_req   = s_axis_tuser[0];
  assign in_start = s_axis_tuser[1];

  hufd_pkg::state_e state_q, state_d;

  logic [hufd_pkg::PadW-1:0]  pad_q;
  logic [IdxW-1:0]            root_q;
  logic [IdxW-1:0]            cur_idx_q, cur_idx_d;
  logic [IdxW-1:0]            child_idx_q, child_idx_d;
  hufd_pkg::node_t            cur_ent_q, cur_ent_d;
  hufd_pkg::node_t            root_ent_q, root_ent_d;
  logic [hufd_pkg::ByteW-1:0] sh_q, sh_d;
  logic [RemW-1:0]            rem_q, rem_d;
  logic                       pend_vld_q, pend_vld_d;
  logic [SymW-1:0]            pend_sym_q, pend_sym_d;
  logic                       out_vld_q, out_vld_d;
  logic [SymW-1:0]            out_sym_q, out_sym_d;
  logic                       out_last_q, out_last_d;

  // tree store
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  hufd_pkg::node_t   ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  hufd_pkg::node_t   ram_rdata;
  logic [IdxW-1:0]   rd_idx;

  hufd_ram #(
    .Width (hufd_pkg::NodeW),
    .Depth (NODE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic                    in_acc;
  logic                    load_ok;
  logic [SymW-1:0]         sym_sat;
  logic                    slot_free;
  logic                    step_bit;
  logic [CW-1:0]           child;
  logic                    child_ok;
  logic                    child_leaf;
  logic                    root_in_range;
  logic                    cur_in_range;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign load_ok   = (CW'(in_idx) < CW'(NODE_DEPTH));
  assign sym_sat   = ({1'b0, in_sym} >= (SymW+1)'(ALPHABET_SIZE)) ?
                     SymW'(ALPHABET_SIZE - 1) : in_sym;
  assign ram_we    = in_acc && (in_req == hufd_pkg::ReqLoad) && load_ok;
  assign ram_waddr = in_idx[AddrW-1:0];
  assign ram_wdata = '{right: in_right, left: in_left, sym: sym_sat};

  assign slot_free     = !out_vld_q || m_axis_tready;
  assign step_bit      = sh_q[0];
  assign child         = step_bit ? cur_ent_q.right : cur_ent_q.left;
  assign child_ok      = !child[CW-1] && (child < CW'(NODE_DEPTH));
  assign child_leaf    = ram_rdata.left[CW-1] || ram_rdata.right[CW-1];
  assign root_in_range = (CW'(root_q) < CW'(NODE_DEPTH));
  assign cur_in_range  = (CW'(cur_idx_q) < CW'(NODE_DEPTH));

  always_comb begin
    unique case (state_q)
      hufd_pkg::StRoot: rd_idx = cur_idx_q;
      hufd_pkg::StStep: rd_idx = child[IdxW-1:0];
      hufd_pkg::StChk:  rd_idx = child_idx_q;
      default:          rd_idx = root_q;
    endcase
  end

  assign ram_raddr = rd_idx[AddrW-1:0];

  assign s_axis_tready = (state_q == hufd_pkg::StIdle) && !pend_vld_q;

  always_comb begin
    state_d     = state_q;
    cur_idx_d   = cur_idx_q;
    child_idx_d = child_idx_q;
    cur_ent_d   = cur_ent_q;
    root_ent_d  = root_ent_q;
    sh_d        = sh_q;
    rem_d       = rem_q;
    pend_vld_d  = pend_vld_q;
    pend_sym_d  = pend_sym_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      hufd_pkg::StIdle: begin
        if (pend_vld_q) begin
          // byte done, last symbol goes out
          if (slot_free) begin
            out_vld_d  = 1'b1;
            out_sym_d  = pend_sym_q;
            out_last_d = 1'b1;
            pend_vld_d = 1'b0;
          end
        end else if (in_acc && (in_req == hufd_pkg::ReqDecode)) begin
          if (in_start) begin
            cur_idx_d = root_q;
            sh_d      = in_byte >> pad_q;
            rem_d     = RemW'(hufd_pkg::ByteW) - RemW'(pad_q);
          end else begin
            sh_d      = in_byte;
            rem_d     = RemW'(hufd_pkg::ByteW);
          end
          state_d = hufd_pkg::StRoot;
        end
      end
      hufd_pkg::StRoot: begin
        root_ent_d = root_in_range ? ram_rdata : hufd_pkg::AbsentNode;
        state_d    = hufd_pkg::StCur;
      end
      hufd_pkg::StCur: begin
        cur_ent_d = cur_in_range ? ram_rdata : hufd_pkg::AbsentNode;
        state_d   = hufd_pkg::StStep;
      end
      hufd_pkg::StStep: begin
        if (rem_q == '0) begin
          state_d = hufd_pkg::StIdle;
        end else if (!child_ok) begin
          cur_ent_d = root_ent_q;
          cur_idx_d = root_q;
          sh_d      = sh_q >> 1;
          rem_d     = rem_q - 1'b1;
        end else begin
          child_idx_d = child[IdxW-1:0];
          state_d     = hufd_pkg::StChk;
        end
      end
      hufd_pkg::StChk: begin
        if (!child_leaf) begin
          cur_ent_d = ram_rdata;
          cur_idx_d = child_idx_q;
          sh_d      = sh_q >> 1;
          rem_d     = rem_q - 1'b1;
          state_d   = hufd_pkg::StStep;
        end else if (!pend_vld_q || slot_free) begin
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_sym_d  = pend_sym_q;
            out_last_d = 1'b0;
          end
          pend_vld_d = 1'b1;
          pend_sym_d = ram_rdata.sym;
          cur_ent_d  = root_ent_q;
          cur_idx_d  = root_q;
          sh_d       = sh_q >> 1;
          rem_d      = rem_q - 1'b1;
          state_d    = hufd_pkg::StStep;
        end
      end
      default: state_d = hufd_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hufd_pkg::StIdle;
      pad_q      <= '0;
      root_q     <= '0;
      cur_idx_q  <= '0;
      rem_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_idx_q  <= cur_idx_d;
      rem_q      <= rem_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          hufd_pkg::RegPadBits:   pad_q  <= cfg_wdata_i[hufd_pkg::PadW-1:0];
          hufd_pkg::RegRootIndex: root_q <= cfg_wdata_i[IdxW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    child_idx_q <= child_idx_d;
    cur_ent_q   <= cur_ent_d;
    root_ent_q  <= root_ent_d;
    sh_q        <= sh_d;
    pend_sym_q  <= pend_sym_d;
    out_sym_q   <= out_sym_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_sym_q;
  assign m_axis_tlast  = out_last_q;

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= RemW'(hufd_pkg::ByteW))
    else $error("bit count beyond a byte");

  a_chk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hufd_pkg::StChk) |-> (CW'(child_idx_q) < CW'(NODE_DEPTH)))
    else $error("child read outside the tree store");

  a_pend_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !pend_vld_q)
    else $error("new word taken with a symbol still pending");

  a_last_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hufd_pkg::StIdle && pend_vld_q && slot_free)
    |=> (m_axis_tvalid && m_axis_tlast && !pend_vld_q))
    else $error("final symbol of a byte not marked last");

endmodule

`default_nettype wire

/* dv/huffman_tree_walk_decoder_test.sv */
`default_nettype none

module huffman_tree_walk_decoder_test;

  localparam int SettleCycles  = 40;
  localparam int WatchdogLimit = 4000;
  localparam logic [hufd_pkg::ChildW-1:0] NoChild = 10'h3FF;

  typedef struct packed {
    logic                        req;
    logic [hufd_pkg::IdxW-1:0]   idx;
    logic [hufd_pkg::SymW-1:0]   sym;
    logic [hufd_pkg::ChildW-1:0] left;
    logic [hufd_pkg::ChildW-1:0] right;
    logic [hufd_pkg::ByteW-1:0]  data;
    logic                        sos;
  } word_t;

  typedef struct packed {
    logic [hufd_pkg::SymW-1:0] sym;
    logic                      last;
  } decoded_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [hufd_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic [hufd_pkg::InUserW-1:0]  s_axis_tuser = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [7:0]                    m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          cfg_we_i = 1'b0;
  logic [hufd_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [hufd_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  hufd_pkg::node_t           tree_mirror [512];
  bit                        node_loaded [512];
  int                        loaded_list [$];
  logic [hufd_pkg::IdxW-1:0] walk_node = '0;
  logic [hufd_pkg::PadW-1:0] pad_reg = '0;
  logic [hufd_pkg::IdxW-1:0] root_reg = '0;
  decoded_t                  symbols_due [$];
  decoded_t                  due_now;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  huffman_tree_walk_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic report_mismatch(input string what, input int expected, input int actual);
    $display("mismatch at %0t: %s expected %0h got %0h", $time, what, expected, actual);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (symbols_due.size() == 0) begin
        report_mismatch("symbol with none due", 0, m_axis_tdata);
      end else begin
        due_now = symbols_due.pop_front();
        if (m_axis_tdata !== due_now.sym) begin
          report_mismatch("symbol", due_now.sym, m_axis_tdata);
        end
        if (m_axis_tlast !== due_now.last) begin
          report_mismatch("last of byte", due_now.last, m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout at %0t, %0d symbols still due", $time, symbols_due.size());
        $display("** huffman_tree_walk_decoder: FAILED **");
        $finish;
      end
    end
  end

  // walks one compressed byte through the mirrored tree, lsb first
  task automatic walk_byte(input logic [hufd_pkg::ByteW-1:0] b, input logic sos);
    int first;
    int i;
    int n_found;
    hufd_pkg::node_t nd;
    hufd_pkg::node_t cn;
    logic [hufd_pkg::ChildW-1:0] ch;
    logic [hufd_pkg::SymW-1:0] found [8];
    decoded_t d;
    first = 0;
    n_found = 0;
    if (sos) begin
      walk_node = root_reg;
      first = pad_reg;
    end
    for (i = first; i < 8; i++) begin
      nd = tree_mirror[walk_node];
      ch = b[i] ? nd.right : nd.left;
      if (ch[hufd_pkg::ChildW-1]) begin
        walk_node = root_reg;
        continue;
      end
      cn = tree_mirror[ch[hufd_pkg::IdxW-1:0]];
      if (cn.left[hufd_pkg::ChildW-1] || cn.right[hufd_pkg::ChildW-1]) begin
        found[n_found] = cn.sym;
        n_found++;
        walk_node = root_reg;
      end else begin
        walk_node = ch[hufd_pkg::IdxW-1:0];
      end
    end
    for (i = 0; i < n_found; i++) begin
      d.sym = found[i];
      d.last = (i == n_found - 1);
      symbols_due = {symbols_due, d};
    end
  endtask

  task automatic send_word(input word_t w);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, w.data, w.right, w.left, w.sym, w.idx};
    s_axis_tuser <= {w.sos, w.req};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (w.req == hufd_pkg::ReqLoad) begin
      tree_mirror[w.idx] = '{right: w.right, left: w.left, sym: w.sym};
      if (!node_loaded[w.idx]) begin
        node_loaded[w.idx] = 1'b1;
        loaded_list = {loaded_list, int'(w.idx)};
      end
    end else begin
      walk_byte(w.data, w.sos);
    end
  endtask

  function automatic word_t load_word(input logic [hufd_pkg::IdxW-1:0] idx,
                                      input logic [hufd_pkg::SymW-1:0] sym,
                                      input logic [hufd_pkg::ChildW-1:0] l,
                                      input logic [hufd_pkg::ChildW-1:0] r);
    word_t w;
    w.req = hufd_pkg::ReqLoad;
    w.idx = idx;
    w.sym = sym;
    w.left = l;
    w.right = r;
    w.data = 8'($urandom);
    w.sos = 1'($urandom);
    return w;
  endfunction

  function automatic word_t byte_word(input logic [hufd_pkg::ByteW-1:0] data, input logic sos);
    word_t w;
    w.req = hufd_pkg::ReqDecode;
    w.idx = 9'($urandom);
    w.sym = 8'($urandom);
    w.left = 10'($urandom);
    w.right = 10'($urandom);
    w.data = data;
    w.sos = sos;
    return w;
  endfunction

  // valid children only ever point at loaded entries
  function automatic logic [hufd_pkg::IdxW-1:0] pick_loaded();
    return 9'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
  endfunction

  function automatic logic [hufd_pkg::ChildW-1:0] noise_child();
    case ($urandom_range(0, 3))
      0: return NoChild;
      1: return {1'b1, 9'($urandom)};
      default: return {1'b0, pick_loaded()};
    endcase
  endfunction

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [hufd_pkg::PadW-1:0] pad,
                          input logic [hufd_pkg::IdxW-1:0] root);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= hufd_pkg::RegPadBits;
    cfg_wdata_i <= {6'($urandom), pad};
    @(posedge clk_i);
    cfg_idx_i <= hufd_pkg::RegRootIndex;
    cfg_wdata_i <= root;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pad_reg = pad;
    root_reg = root;
  endtask

  task automatic test_reset_walk();
    send_word(load_word(9'd0, 8'h30, 10'd1, 10'd2));
    send_word(load_word(9'd1, 8'h41, NoChild, NoChild));
    send_word(load_word(9'd2, 8'h42, 10'd1, 10'd3));
    send_word(load_word(9'd3, 8'h43, NoChild, 10'd0));
    send_word(byte_word(8'h96, 1'b0));
    send_word(byte_word(8'h3C, 1'b0));
    send_word(byte_word(8'h5B, 1'b1));
    wait_idle();
    set_regs(3'd5, 9'd0);
    send_word(byte_word(8'hE7, 1'b1));
    wait_idle();
  endtask

  task automatic test_fixed_tree();
    send_word(load_word(9'd511, 8'hC3, 10'd0, 10'd300));
    send_word(load_word(9'd0, 8'h00, NoChild, NoChild));
    send_word(load_word(9'd300, 8'h11, 10'd5, 10'd6));
    send_word(load_word(9'd5, 8'hFF, NoChild, 10'd6));
    send_word(load_word(9'd6, 8'h5A, 10'h200, NoChild));
    send_word(load_word(9'd20, 8'h77, NoChild, 10'd300));
    wait_idle();
    set_regs(3'd0, 9'd511);
    send_word(byte_word(8'h00, 1'b1));
    send_word(byte_word(8'hFF, 1'b0));
    send_word(byte_word(8'hA5, 1'b0));
    wait_idle();
    // root with only a right child, so every zero bit is a dead step
    set_regs(3'd7, 9'd20);
    send_word(byte_word(8'h7F, 1'b1));
    send_word(byte_word(8'hFF, 1'b0));
    send_word(byte_word(8'h00, 1'b0));
    wait_idle();
    set_regs(3'd3, 9'd511);
    send_word(byte_word(8'hF0, 1'b1));
    wait_idle();
  endtask

  task automatic load_random_tree(input int n_leaves, output logic [hufd_pkg::IdxW-1:0] root);
    int subtrees [$];
    bit used [512];
    int idx;
    int a;
    int b;
    int p;
    int k;
    logic [hufd_pkg::ChildW-1:0] l;
    logic [hufd_pkg::ChildW-1:0] r;
    for (k = 0; k < n_leaves; k++) begin
      do idx = $urandom_range(0, 511); while (used[idx]);
      used[idx] = 1'b1;
      case ($urandom_range(0, 3))
        0: begin l = NoChild; r = NoChild; end
        1: begin l = NoChild; r = {1'b0, pick_loaded()}; end
        2: begin l = {1'b0, pick_loaded()}; r = NoChild; end
        default: begin l = {1'b1, 9'($urandom)}; r = noise_child(); end
      endcase
      send_word(load_word(9'(idx), 8'($urandom), l, r));
      subtrees = {subtrees, idx};
    end
    while (subtrees.size() > 1) begin
      p = $urandom_range(0, subtrees.size() - 1);
      a = subtrees[p];
      subtrees.delete(p);
      p = $urandom_range(0, subtrees.size() - 1);
      b = subtrees[p];
      subtrees.delete(p);
      do idx = $urandom_range(0, 511); while (used[idx]);
      used[idx] = 1'b1;
      send_word(load_word(9'(idx), 8'($urandom), 10'(a), 10'(b)));
      subtrees = {subtrees, idx};
    end
    root = 9'(subtrees[0]);
  endtask

  task automatic test_random_trees(input int quota);
    int start;
    int n;
    int n_bytes;
    int k;
    logic sos;
    logic [hufd_pkg::IdxW-1:0] root;
    start = items_sent;
    while (items_sent - start < quota) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 10) : $urandom_range(2, 5);
      load_random_tree(n, root);
      wait_idle();
      if ($urandom_range(0, 7) == 0) begin
        root = pick_loaded();
      end
      set_regs(3'($urandom), root);
      n_bytes = $urandom_range(3, 10);
      for (k = 0; k < n_bytes; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          send_word(load_word(9'($urandom), 8'($urandom), noise_child(), noise_child()));
        end
        sos = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0);
        send_word(byte_word(8'($urandom), sos));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_walk();
    test_fixed_tree();
    test_random_trees(18);
    idle_pct = 49;
    stall_pct = 0;
    test_random_trees(18);
    idle_pct = 0;
    stall_pct = 49;
    test_random_trees(18);
    idle_pct = 26;
    stall_pct = 26;
    test_random_trees(18);
    wait_idle();
    if (mismatches == 0) begin
      $display("** huffman_tree_walk_decoder: PASSED **");
    end else begin
      $display("** huffman_tree_walk_decoder: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
